// File: design/lcg_modular_shift_add_macros.svh
// Assertion shorthands used by the bound checker file of this block.
`ifndef LCG_MODULAR_SHIFT_ADD_MACROS_SVH
`define LCG_MODULAR_SHIFT_ADD_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define LCG_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("lcg assertion failed");

// Next-cycle implication, disabled while reset is high.
`define LCG_ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("lcg assertion failed");

`endif

// File: design/lcg_pkg.sv
package lcg_pkg;

  localparam int WORD_W     = 64;
  localparam int OUT_W      = 63;
  localparam int CFG_IDX_W  = 2;
  localparam int STEP_CNT_W = $clog2(WORD_W);

  localparam logic [WORD_W-1:0] TOP_MOD = {1'b1, {(WORD_W-1){1'b0}}};

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MULT = 2'd0,
    REG_INCR = 2'd1,
    REG_MOD  = 2'd2,
    REG_SEED = 2'd3
  } cfg_reg_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic reduce_step;
    logic mult_step;
    logic finish;
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic mult_done;
  } dp_status_t;

endpackage

// File: design/lcg_ctrl.sv
module lcg_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  output lcg_pkg::dp_cmd_t    cmd,
  input  lcg_pkg::dp_status_t status
);
  import lcg_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_REDUCE,
    S_MULT,
    S_FINISH
  } state_t;

  localparam logic [STEP_CNT_W-1:0] LAST_STEP = STEP_CNT_W'(WORD_W - 1);

  state_t                state;
  logic [STEP_CNT_W-1:0] step_cnt;
  logic                  out_free;

  assign out_free = !out_valid || out_ready;
  assign in_ready = (state == S_IDLE);

  always_comb begin
    cmd = '0;
    case (state)
      S_IDLE:   cmd.load        = in_valid;
      S_REDUCE: cmd.reduce_step = 1'b1;
      S_MULT:   cmd.mult_step   = !status.mult_done;
      S_FINISH: cmd.finish      = out_free;
      default:  cmd = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      step_cnt  <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            step_cnt <= '0;
            state    <= S_REDUCE;
          end
        end
        S_REDUCE: begin
          step_cnt <= step_cnt + 1'b1;
          if (step_cnt == LAST_STEP) begin
            state <= S_MULT;
          end
        end
        S_MULT: begin
          if (status.mult_done) begin
            state <= S_FINISH;
          end
        end
        S_FINISH: begin
          if (out_free) begin
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// File: design/lcg_dp.sv
module lcg_dp (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_wr_en,
  input  logic [lcg_pkg::CFG_IDX_W-1:0]         cfg_addr,
  input  logic [lcg_pkg::WORD_W-1:0]            cfg_wdata,
  input  logic                                  restart,
  input  lcg_pkg::dp_cmd_t                      cmd,
  output lcg_pkg::dp_status_t                   status,
  output logic [lcg_pkg::OUT_W-1:0]             rand_out
);
  import lcg_pkg::*;

  logic [WORD_W-1:0] mult_value;
  logic [WORD_W-1:0] incr_value;
  logic [WORD_W-1:0] mod_value;
  logic [WORD_W-1:0] start_seed;

  logic [WORD_W-1:0] cur_seed;
  logic              seeded;

  logic [WORD_W-1:0] modulus;
  logic [WORD_W-1:0] mul;
  logic [WORD_W-1:0] incr_sh;
  logic [WORD_W-1:0] seed_sh;
  logic [WORD_W-1:0] acc;
  logic [WORD_W-1:0] s;

  logic [WORD_W-1:0] mod_eff;
  logic [WORD_W-1:0] acc_shift;
  logic [WORD_W-1:0] s_shift;
  logic [WORD_W-1:0] acc_sum;
  logic [WORD_W-1:0] s_dbl;
  logic [WORD_W-1:0] acc_red_next;
  logic [WORD_W-1:0] s_red_next;
  logic [WORD_W-1:0] acc_mul_next;
  logic [WORD_W-1:0] s_mul_next;

  // A zero or oversized modulus means the full 2^63 range.
  assign mod_eff = (mod_value == '0 || mod_value > TOP_MOD) ? TOP_MOD : mod_value;

  // Both acc and s stay below the modulus, so their top bit is free and no
  // sum or doubling overflows the word.
  assign acc_shift    = {acc[WORD_W-2:0], incr_sh[WORD_W-1]};
  assign s_shift      = {s[WORD_W-2:0], seed_sh[WORD_W-1]};
  assign acc_red_next = (acc_shift >= modulus) ? acc_shift - modulus : acc_shift;
  assign s_red_next   = (s_shift >= modulus) ? s_shift - modulus : s_shift;

  assign acc_sum      = acc + s;
  assign s_dbl        = {s[WORD_W-2:0], 1'b0};
  assign acc_mul_next = (acc_sum >= modulus) ? acc_sum - modulus : acc_sum;
  assign s_mul_next   = (s_dbl >= modulus) ? s_dbl - modulus : s_dbl;

  assign status.mult_done = (mul == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      mult_value <= '0;
      incr_value <= '0;
      mod_value  <= TOP_MOD;
      start_seed <= '0;
      seeded     <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        case (cfg_addr)
          REG_MULT: mult_value <= cfg_wdata;
          REG_INCR: incr_value <= cfg_wdata;
          REG_MOD:  mod_value  <= cfg_wdata;
          REG_SEED: start_seed <= cfg_wdata;
          default:  mult_value <= mult_value;
        endcase
      end
      if (cmd.load) begin
        seeded <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      modulus <= mod_eff;
      mul     <= mult_value;
      incr_sh <= incr_value;
      seed_sh <= (restart || !seeded) ? start_seed : cur_seed;
      acc     <= '0;
      s       <= '0;
    end else if (cmd.reduce_step) begin
      acc     <= acc_red_next;
      s       <= s_red_next;
      incr_sh <= {incr_sh[WORD_W-2:0], 1'b0};
      seed_sh <= {seed_sh[WORD_W-2:0], 1'b0};
    end else if (cmd.mult_step) begin
      if (mul[0]) begin
        acc <= acc_mul_next;
      end
      s   <= s_mul_next;
      mul <= {1'b0, mul[WORD_W-1:1]};
    end
    if (cmd.finish) begin
      cur_seed <= acc;
      rand_out <= acc[OUT_W-1:0];
    end
  end

endmodule

// File: design/lcg_modular_shift_add.sv
// Linear congruential generator with an arbitrary modulus. Each accepted
// item returns one result item, the next seed (incr + mult * seed) mod m,
// where m is the written modulus, or 2^63 when the modulus is zero or above
// 2^63. An item with restart set, and the first item after reset, starts
// from the start seed. Work on an item runs in two phases on the same pair
// of 64-bit registers. First the adder and the seed are reduced modulo m,
// one bit per cycle over all 64 bits, by shift and conditional subtract.
// Then the product is built by shift-and-add, one multiplier bit per cycle
// from the least significant end, stopping as soon as the remaining
// multiplier bits are zero, and the result is then registered. The block
// takes the next item in the cycle after the result is registered, so it
// does not accept a new item before it is through with the last one. The
// result sits in an output register, so a new item is accepted while an
// earlier result still waits; the finish of that new item waits only if
// the old result has still not been taken.
// Configuration registers are written through a plain write port and must
// only change while no item is in flight.
module lcg_modular_shift_add (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_wr_en,
  input  logic [lcg_pkg::CFG_IDX_W-1:0] cfg_addr,
  input  logic [lcg_pkg::WORD_W-1:0]    cfg_wdata,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          restart,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [lcg_pkg::OUT_W-1:0]     rand_out
);
  import lcg_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  // The controller sequences load, reduction, multiplication and finish.
  lcg_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .status    (status)
  );

  // The datapath holds the configuration, the seed state and the separate
  // compare-and-subtract lanes of the two phases.
  lcg_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr_en (cfg_wr_en),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .restart   (restart),
    .cmd       (cmd),
    .status    (status),
    .rand_out  (rand_out)
  );

endmodule

// File: design/lcg_checker.sv
`include "lcg_modular_shift_add_macros.svh"

module lcg_checker (
  input logic                      clk,
  input logic                      rst,
  input logic                      in_valid,
  input logic                      in_ready,
  input logic                      out_valid,
  input logic                      out_ready,
  input logic [lcg_pkg::OUT_W-1:0] rand_out
);
  import lcg_pkg::*;

  // A result that is not taken stays and holds its value.
  `LCG_ASSERT_NXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(rand_out))

  // The block works on one item at a time: it is busy right after an accept.
  `LCG_ASSERT_NXT(a_busy_after_accept, clk, rst, in_valid && in_ready, !in_ready)

  // A new result frees the block for the next item in the same cycle.
  `LCG_ASSERT_IMP(a_ready_with_result, clk, rst, $rose(out_valid), in_ready)

endmodule

bind lcg_modular_shift_add lcg_checker u_lcg_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .rand_out  (rand_out)
);

// File: verif/lcg_modular_shift_add_checker.sv
`timescale 1ns / 1ps

module lcg_modular_shift_add_checker
  import lcg_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_wr_en,
  input  logic [CFG_IDX_W-1:0] cfg_addr,
  input  logic [WORD_W-1:0]    cfg_wdata,
  input  logic                 in_valid,
  input  logic                 in_ready,
  input  logic                 restart,
  input  logic                 out_valid,
  input  logic                 out_ready,
  input  logic [OUT_W-1:0]     rand_out,
  output int                   fail_count,
  output int                   outstanding
);

  logic [WORD_W-1:0] mult_reg;
  logic [WORD_W-1:0] incr_reg;
  logic [WORD_W-1:0] mod_reg;
  logic [WORD_W-1:0] start_reg;
  logic [WORD_W-1:0] seed_now;
  logic              seed_loaded;
  logic [OUT_W-1:0]  expected_rand[$];

  // Next seed (incr + mult * seed) mod m, taken in double width so that no
  // intermediate value can wrap. A zero or oversized modulus means 2^63.
  function automatic logic [WORD_W-1:0] lcg_next_value(input logic [WORD_W-1:0] seed);
    logic [WORD_W-1:0]   m;
    logic [2*WORD_W-1:0] wide;
    m = (mod_reg == '0 || mod_reg > TOP_MOD) ? TOP_MOD : mod_reg;
    wide = (mult_reg % m) * (seed % m) + (incr_reg % m);
    wide = wide % m;
    return wide[WORD_W-1:0];
  endfunction

  initial begin
    fail_count  = 0;
    outstanding = 0;
  end

  always @(posedge clk) begin : watch
    logic [OUT_W-1:0] want;
    if (rst) begin
      mult_reg    = '0;
      incr_reg    = '0;
      mod_reg     = TOP_MOD;
      start_reg   = '0;
      seed_now    = '0;
      seed_loaded = 1'b0;
      expected_rand.delete();
    end else begin
      if (cfg_wr_en) begin
        case (cfg_reg_t'(cfg_addr))
          REG_MULT: mult_reg  = cfg_wdata;
          REG_INCR: incr_reg  = cfg_wdata;
          REG_MOD:  mod_reg   = cfg_wdata;
          REG_SEED: start_reg = cfg_wdata;
          default:  ;
        endcase
      end
      // Results are retired before new items are queued, so a result can
      // never be matched against the item accepted in the same cycle.
      if (out_valid && out_ready) begin
        if (expected_rand.size() == 0) begin
          $display("%0t: result with no item pending, expected none, got %0d",
                   $time, rand_out);
          fail_count++;
        end else begin
          want = expected_rand.pop_front();
          if (rand_out !== want) begin
            $display("%0t: rand_out mismatch, expected %0d, got %0d",
                     $time, want, rand_out);
            fail_count++;
          end
        end
      end
      if (in_valid && in_ready) begin
        if (restart || !seed_loaded) begin
          seed_now    = start_reg;
          seed_loaded = 1'b1;
        end
        seed_now = lcg_next_value(seed_now);
        expected_rand.push_back(seed_now[OUT_W-1:0]);
      end
    end
    outstanding = expected_rand.size();
  end

endmodule

// File: verif/lcg_modular_shift_add_tb.sv
`timescale 1ns / 1ps

module lcg_modular_shift_add_tb;
  import lcg_pkg::*;

  // Traffic shapes for one phase of the run. The sender idles before an item
  // and the receiver stalls per cycle, each with the percentage picked below.
  typedef enum int {
    IDLE_NONE,
    IDLE_SEND,
    IDLE_RECV,
    IDLE_BOTH
  } idle_mode_t;

  localparam int ITEM_TARGET  = 2000;
  // Long enough to fill the output register and the item in flight.
  localparam int HOLD_CYCLES  = 400;
  // Time for any stray late result to show up.
  localparam int DRAIN_CYCLES = 200;

  logic                 clk = 1'b0;
  logic                 rst;
  logic                 cfg_wr_en;
  logic [CFG_IDX_W-1:0] cfg_addr;
  logic [WORD_W-1:0]    cfg_wdata;
  logic                 in_valid;
  logic                 in_ready;
  logic                 restart;
  logic                 out_valid;
  logic                 out_ready;
  logic [OUT_W-1:0]     rand_out;

  idle_mode_t idle_mode;
  logic       hold_req;
  int         fail_count;
  int         outstanding;
  int         items_sent;
  int         phase_num;
  int         batch_len;

  always #10 clk = ~clk;

  lcg_modular_shift_add i_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr_en (cfg_wr_en),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .restart   (restart),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .rand_out  (rand_out)
  );

  // The checker follows the register writes and both channels on its own and
  // reports how many checks failed and how many results are still owed.
  lcg_modular_shift_add_checker i_checker (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_addr    (cfg_addr),
    .cfg_wdata   (cfg_wdata),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .restart     (restart),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .rand_out    (rand_out),
    .fail_count  (fail_count),
    .outstanding (outstanding)
  );

  // Percentage of cycles in which the given side holds back in a mode.
  function automatic int stall_pct(input idle_mode_t mode, input logic sender);
    case (mode)
      IDLE_SEND: return sender ? 81 : 0;
      IDLE_RECV: return sender ? 0 : 81;
      IDLE_BOTH: return 7;
      default:   return 0;
    endcase
  endfunction

  function automatic logic [WORD_W-1:0] rand_word();
    return {$urandom, $urandom};
  endfunction

  // Moduli lean toward the edges: one, zero, exactly 2^63 and just below it,
  // tiny values, 32-bit values, and full 64-bit values, half of which saturate.
  function automatic logic [WORD_W-1:0] pick_modulus();
    case ($urandom_range(7))
      0:       return 64'd1;
      1:       return '0;
      2:       return TOP_MOD;
      3:       return TOP_MOD - 64'd1;
      4:       return 64'($urandom_range(2, 50));
      5:       return {32'h0, $urandom};
      default: return rand_word();
    endcase
  endfunction

  // Multiplier and adder: zero, all ones, small, 32-bit, full width.
  function automatic logic [WORD_W-1:0] pick_operand();
    case ($urandom_range(5))
      0:       return '0;
      1:       return '1;
      2:       return 64'($urandom_range(1, 15));
      3:       return {32'h0, $urandom};
      default: return rand_word();
    endcase
  endfunction

  // Receiver. Each falling edge it decides whether to take a result in the
  // next cycle. Once, on request, it refuses results for a long stretch while
  // the sender keeps offering items, so the block backs up into its input.
  initial begin : receiver
    logic held;
    held      = 1'b0;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req && !held) begin
        held = 1'b1;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end
      out_ready <= ($urandom_range(99) >= stall_pct(idle_mode, 1'b0));
    end
  end

  // One register write per cycle; the enable stays high across a burst.
  task automatic write_reg(input cfg_reg_t idx, input logic [WORD_W-1:0] value);
    cfg_wr_en <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= value;
    @(negedge clk);
  endtask

  task automatic load_config(input logic [WORD_W-1:0] mult, input logic [WORD_W-1:0] incr,
                             input logic [WORD_W-1:0] modulus,
                             input logic [WORD_W-1:0] seed);
    write_reg(REG_MULT, mult);
    write_reg(REG_INCR, incr);
    write_reg(REG_MOD, modulus);
    write_reg(REG_SEED, seed);
    cfg_wr_en <= 1'b0;
  endtask

  // Offer one item and return at the falling edge after it was taken. Valid
  // is left high so back-to-back items keep it up without a glitch. While
  // the sender idles, the restart line carries junk that must be ignored.
  task automatic send_item(input logic restart_bit);
    int pct;
    pct = stall_pct(idle_mode, 1'b1);
    while ($urandom_range(99) < pct) begin
      in_valid <= 1'b0;
      restart  <= 1'($urandom_range(1));
      @(negedge clk);
    end
    in_valid <= 1'b1;
    restart  <= restart_bit;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  // Drop valid and wait until every result owed has been taken. Each item
  // yields exactly one result, so the block is idle at that point and the
  // registers may be rewritten.
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
  endtask

  // A directed setting: continue the old sequence under the new registers
  // (the carried-over seed gets reduced by the new modulus), then restart
  // from the start seed, then continue again.
  task automatic run_directed(input logic [WORD_W-1:0] mult, input logic [WORD_W-1:0] incr,
                              input logic [WORD_W-1:0] modulus,
                              input logic [WORD_W-1:0] seed);
    load_config(mult, incr, modulus, seed);
    send_item(1'b0);
    send_item(1'b1);
    send_item(1'b0);
    wait_drained();
  endtask

  initial begin
    rst       = 1'b1;
    cfg_wr_en = 1'b0;
    cfg_addr  = REG_MULT;
    cfg_wdata = '0;
    in_valid  = 1'b0;
    restart   = 1'b0;
    idle_mode = IDLE_NONE;
    hold_req  = 1'b0;
    items_sent = 0;
    phase_num  = 0;

    repeat (11) @(negedge clk);
    rst <= 1'b0;

    // First item after reset, with the reset register values and restart
    // low: the start seed must still be loaded.
    send_item(1'b0);
    wait_drained();

    // Modulus of one: every result is zero whatever the operands.
    run_directed('1, '1, 64'd1, '1);
    // Zero modulus stands for the full 2^63 range.
    run_directed('1, '1, '0, '1);
    // Oversized modulus saturates; every operand is at or above it.
    run_directed(64'h8000_0000_0000_0005, TOP_MOD, '1, 64'hFFFF_FFFF_FFFF_FFFE);
    // Modulus of exactly 2^63 with identity multiplier: the restart item
    // returns the largest possible result.
    run_directed(64'd1, '0, TOP_MOD, TOP_MOD - 64'd1);
    // Modulus just below 2^63; the start seed reduces to zero.
    run_directed(TOP_MOD - 64'd2, TOP_MOD - 64'd2, TOP_MOD - 64'd1, TOP_MOD - 64'd1);
    // Modulus just above 2^63 saturates, alternating bit patterns.
    run_directed(64'h5555_5555_5555_5555, '0, TOP_MOD + 64'd1, 64'hAAAA_AAAA_AAAA_AAAA);
    // Zero multiplier: result is the reduced adder.
    run_directed('0, 64'd3, 64'd2, 64'd7);

    // Random phases. Each one draws fresh registers and cycles through the
    // traffic shapes; one phase without idling also carries the long
    // receiver hold-off. About one item in eight restarts the sequence.
    while (items_sent < ITEM_TARGET) begin
      load_config(pick_operand(), pick_operand(), pick_modulus(), rand_word());
      case (phase_num % 4)
        0:       idle_mode = IDLE_NONE;
        1:       idle_mode = IDLE_SEND;
        2:       idle_mode = IDLE_RECV;
        default: idle_mode = IDLE_BOTH;
      endcase
      if (phase_num == 4) hold_req = 1'b1;
      batch_len = $urandom_range(40, 120);
      repeat (batch_len) send_item($urandom_range(7) == 0);
      items_sent += batch_len;
      wait_drained();
      phase_num++;
    end

    // Give a late or duplicated result time to show up before the verdict.
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (fail_count == 0 && outstanding == 0) begin
      $display("lcg_modular_shift_add_tb OK");
    end else begin
      $display("lcg_modular_shift_add_tb NOT OK");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run, even with every item at its
  // longest multiply and every stall at its worst.
  initial begin
    #80_000_000;
    $display("lcg_modular_shift_add_tb NOT OK");
    $finish;
  end

endmodule

// File: filelist.f
+incdir+design
design/lcg_pkg.sv
design/lcg_ctrl.sv
design/lcg_dp.sv
design/lcg_modular_shift_add.sv
design/lcg_checker.sv
verif/lcg_modular_shift_add_checker.sv
verif/lcg_modular_shift_add_tb.sv
